// File: hw/rtl/nnr_pkg.sv
// Shared constants and types for the nearest neighbor resampler.
// Used by nnr_ctrl, nnr_datapath and nearest_neighbor_resampler_core.
`default_nettype none

package nnr_pkg;

  // Sample and accumulator widths.
  localparam int SampleW = 16;
  localparam int PhaseW  = 32;

  // Configuration port.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] REG_PHASE_STEP   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_INTERP_MODE  = 1'd1;
  localparam logic [PhaseW-1:0]  PHASE_STEP_RESET = 32'h8000_0000;

  // Largest number of results one interpolated item may cause.
  localparam int MaxRes = 64;
  localparam int CntW   = $clog2(MaxRes + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;        // advance the accumulator by one step
    logic capture;     // hold the input sample for an interpolation burst
    logic load_out;    // load the output register
    logic out_from_in; // output comes from the input ports, not the held sample
    logic out_last;    // mark the loaded result as the item's final one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic interp;      // interpolate mode is configured
    logic wrap_dec;    // current phase is not above the previous phase
    logic wrap_int;    // the next step would wrap
    logic out_free;    // the output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/nnr_datapath.sv
// Datapath of the resampler: configuration registers, phase accumulator,
// held sample and output register. Depends on nnr_pkg.
`default_nettype none

module nnr_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [nnr_pkg::CfgIdxW-1:0]          cfg_index,
  input  wire logic [nnr_pkg::CfgDataW-1:0]         cfg_wdata,
  input  wire logic signed [nnr_pkg::SampleW-1:0]   in_sample_i,
  input  wire logic signed [nnr_pkg::SampleW-1:0]   in_sample_q,
  input  wire nnr_pkg::cmd_t                        cmd,
  output nnr_pkg::sts_t                             sts,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [nnr_pkg::SampleW-1:0]        out_i,
  output logic signed [nnr_pkg::SampleW-1:0]        out_q,
  output logic                                      out_last
);

  logic [nnr_pkg::PhaseW-1:0]         phase_step_r;
  logic                               interp_mode_r;
  logic [nnr_pkg::PhaseW-1:0]         phase_r;
  logic [nnr_pkg::PhaseW-1:0]         prev_phase_r;
  logic [nnr_pkg::PhaseW-1:0]         phase_nxt;
  logic signed [nnr_pkg::SampleW-1:0] hold_i_r;
  logic signed [nnr_pkg::SampleW-1:0] hold_q_r;
  logic                               out_valid_r;
  logic signed [nnr_pkg::SampleW-1:0] out_i_r;
  logic signed [nnr_pkg::SampleW-1:0] out_q_r;
  logic                               out_last_r;

  // One accumulator step; the sum wraps modulo two to the 32.
  assign phase_nxt = phase_r + phase_step_r;

  // Status back to the controller.
  always_comb begin
    sts.interp   = interp_mode_r;
    sts.wrap_dec = (phase_r <= prev_phase_r);
    sts.wrap_int = (phase_nxt <= phase_r);
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Configuration registers; user writes only while idle, not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= nnr_pkg::PHASE_STEP_RESET;
      interp_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        nnr_pkg::REG_PHASE_STEP:  phase_step_r  <= cfg_wdata[nnr_pkg::PhaseW-1:0];
        nnr_pkg::REG_INTERP_MODE: interp_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Phase accumulator and the value before its last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      prev_phase_r <= '0;
    end else if (cmd.step) begin
      prev_phase_r <= phase_r;
      phase_r      <= phase_nxt;
    end
  end

  // Sample held for the length of an interpolation burst.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold_i_r <= in_sample_i;
      hold_q_r <= in_sample_q;
    end
  end

  // Output register; it takes a new item in the cycle its old one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_i_r    <= cmd.out_from_in ? in_sample_i : hold_i_r;
      out_q_r    <= cmd.out_from_in ? in_sample_q : hold_q_r;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/nnr_ctrl.sv
// Controller of the resampler: item acceptance, burst sequencing and the
// owed wrap emission. Depends on nnr_pkg; drives nnr_datapath commands.
`default_nettype none

module nnr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire nnr_pkg::sts_t sts,
  output nnr_pkg::cmd_t      cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      pending_r, pending_nxt;
  logic                      held_r, held_nxt;
  logic [nnr_pkg::CntW-1:0]  cnt_r, cnt_nxt;

  // Next state and commands. In a burst, a result is held back until the
  // following step tells whether it is the item's final one.
  always_comb begin
    state_nxt   = state_r;
    pending_nxt = pending_r;
    held_nxt    = held_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    in_stall    = !((state_r == ST_IDLE) && sts.out_free);
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.out_free) begin
          if (!sts.interp) begin
            // Decimate: one step, pass the sample on a wrap.
            cmd.step        = 1'b1;
            cmd.load_out    = sts.wrap_dec;
            cmd.out_from_in = 1'b1;
            cmd.out_last    = 1'b1;
            pending_nxt     = 1'b0;
          end else begin
            // Interpolate: an owed wrap makes the sample the first result.
            cmd.capture = 1'b1;
            held_nxt    = pending_r;
            cnt_nxt     = pending_r ? nnr_pkg::CntW'(1) : '0;
            pending_nxt = 1'b0;
            state_nxt   = ST_BURST;
          end
        end
      end
      ST_BURST: begin
        if (held_r && (cnt_r == nnr_pkg::CntW'(nnr_pkg::MaxRes))) begin
          // Burst cap reached: release the last result, record no wrap.
          if (sts.out_free) begin
            cmd.load_out = 1'b1;
            cmd.out_last = 1'b1;
            held_nxt     = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end else if (!held_r || sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.wrap_int) begin
            // Wrap ends the burst; the next item is owed an emission.
            pending_nxt  = 1'b1;
            cmd.load_out = held_r;
            cmd.out_last = 1'b1;
            held_nxt     = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.load_out = held_r;
            cmd.out_last = 1'b0;
            held_nxt     = 1'b1;
            cnt_nxt      = cnt_r + nnr_pkg::CntW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and burst bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pending_r <= 1'b0;
      held_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      held_r    <= held_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/nearest_neighbor_resampler_core.sv
// Nearest neighbor resampler for complex 16-bit I/Q samples, driven by a
// 32-bit phase accumulator. The input channel takes an item (in_sample_i,
// in_sample_q) when in_valid is high and in_stall low; the output channel
// gives out_i, out_q and out_last, which marks the final result of an item,
// under out_valid and out_stall. Configuration: cfg_we with cfg_index 0
// writes phase_step, index 1 writes interpolate_mode (bit 0).
// Decimate mode takes one item per cycle while the output is not stalled; a
// passed sample appears on the output in the cycle after acceptance.
// Interpolate mode holds the item for one accumulator step per cycle
// while the output can take a result; its first result passes through
// the held sample register and then the output register.
// While the receiver stalls, the output register holds its item, the
// burst pauses before the next result and no new item is taken.
// Synchronous reset (rst_n low) sets phase_step to 0x80000000, decimate
// mode, both phases to zero, clears the owed wrap and empties the output.
// Depends on nnr_pkg, nnr_ctrl and nnr_datapath.
`default_nettype none

module nearest_neighbor_resampler_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [nnr_pkg::CfgIdxW-1:0]          cfg_index,
  input  wire logic [nnr_pkg::CfgDataW-1:0]         cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [nnr_pkg::SampleW-1:0]   in_sample_i,
  input  wire logic signed [nnr_pkg::SampleW-1:0]   in_sample_q,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [nnr_pkg::SampleW-1:0]        out_i,
  output logic signed [nnr_pkg::SampleW-1:0]        out_q,
  output logic                                      out_last
);

  nnr_pkg::cmd_t cmd;
  nnr_pkg::sts_t sts;

  // Sequencing of items and bursts.
  nnr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Accumulator, configuration and output register.
  nnr_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_sample_i (in_sample_i),
    .in_sample_q (in_sample_q),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_i       (out_i),
    .out_q       (out_q),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire
